// ----- rtl/pfc_pkg.sv -----
// Shared definitions for the Playfair digram cipher engine.
// Holds letter codes, command codes, the queued operation type and helpers.
// No dependencies.
package pfc_pkg;

  localparam int SQUARE_SIDE = 5;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;
  localparam int CMD_W       = 2;

  localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd3;

  localparam logic REG_DECRYPT = 1'b0;
  localparam logic REG_FILLER  = 1'b1;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_DONE = 2'd1,
    OP_TEXT = 2'd2,
    OP_END  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [LETTER_W-1:0] letter;
    logic                usable;
  } op_t;

  function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] code);
    return (code == LETTER_J) ? LETTER_I : code;
  endfunction

endpackage

// ----- rtl/pfc_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// Used for the key square and the letter position store. No dependencies.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- rtl/pfc_front.sv -----
// Front end: accepts input transactions, classifies them and queues them, dropping text letters with codes above 25.
// Depends on pfc_pkg.
module pfc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pfc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pfc_pkg::LETTER_W-1:0]  in_letter,
  output logic                          op_valid,
  input  logic                          op_ready,
  output pfc_pkg::op_t                  op
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  pfc_pkg::op_t       fifo_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  pfc_pkg::op_t       cls;
  logic               keep;
  logic               push;
  logic               pop;

  always_comb begin
    cls.kind   = pfc_pkg::OP_KEY;
    cls.letter = in_letter;
    cls.usable = 1'b0;
    keep       = 1'b1;
    unique case (in_cmd)
      pfc_pkg::CMD_KEY: begin
        cls.kind   = pfc_pkg::OP_KEY;
        cls.usable = (in_letter <= pfc_pkg::LAST_LETTER) && (in_letter != pfc_pkg::LETTER_J);
      end
      pfc_pkg::CMD_DONE: begin
        cls.kind = pfc_pkg::OP_DONE;
      end
      pfc_pkg::CMD_TEXT: begin
        cls.kind   = pfc_pkg::OP_TEXT;
        cls.letter = pfc_pkg::fold_letter(in_letter);
        cls.usable = 1'b1;
        keep       = (in_letter <= pfc_pkg::LAST_LETTER);
      end
      pfc_pkg::CMD_END: begin
        cls.kind = pfc_pkg::OP_END;
      end
    endcase
  end

  assign in_tready = (count_r != CNT_W'(QDEPTH));
  assign op_valid  = (count_r != '0);
  assign op        = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pfc_back.sv -----
// Back end: builds the key square and substitutes letter pairs.
// Depends on pfc_pkg and pfc_ram (key square and letter position store).
module pfc_back #(
  parameter int SQUARE_SIDE = pfc_pkg::SQUARE_SIDE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  pfc_pkg::op_t                  op,
  input  logic                          cfg_decrypt,
  input  logic [pfc_pkg::LETTER_W-1:0]  cfg_filler,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfc_pkg::LETTER_W-1:0]  out_letter,
  output logic                          out_last
);

  localparam int CELLS    = SQUARE_SIDE * SQUARE_SIDE;
  localparam int POS_W    = $clog2(CELLS);
  localparam int RC_W     = $clog2(SQUARE_SIDE);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int LETTER_W = pfc_pkg::LETTER_W;
  localparam int LETTERS  = pfc_pkg::LETTERS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FILL  = 7'b0000010,
    ST_LOOK  = 7'b0000100,
    ST_POS   = 7'b0001000,
    ST_SQ    = 7'b0010000,
    ST_EMIT0 = 7'b0100000,
    ST_EMIT1 = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LETTERS-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ready_r, ready_nxt;
  logic [LETTER_W-1:0] pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [LETTER_W-1:0] pa_r, pa_nxt;
  logic [LETTER_W-1:0] pb_r, pb_nxt;
  logic                last_r, last_nxt;
  logic [LETTER_W-1:0] fill_r, fill_nxt;
  logic [LETTER_W-1:0] res_a_r, res_a_nxt;
  logic [LETTER_W-1:0] res_b_r, res_b_nxt;
  logic                out_v_r, out_v_nxt;
  logic [LETTER_W-1:0] out_d_r, out_d_nxt;
  logic                out_last_r, out_last_nxt;

  logic                we;
  logic [LETTER_W-1:0] wr_letter;
  logic [POS_W-1:0]    wr_pos;
  logic [POS_W-1:0]    pos_a, pos_b;
  logic [LETTER_W-1:0] sq_a, sq_b;
  logic [POS_W-1:0]    oa, ob;
  logic [RC_W-1:0]     ra, ca, rb, cb;
  logic [LETTER_W-1:0] fcode;
  logic                out_free;

  function automatic logic [RC_W-1:0] row_of(input logic [POS_W-1:0] pos);
    logic [RC_W-1:0] row;
    row = '0;
    for (int r = 1; r < SQUARE_SIDE; r++) begin
      if (pos >= POS_W'(r * SQUARE_SIDE)) begin
        row = RC_W'(r);
      end
    end
    return row;
  endfunction

  function automatic logic [RC_W-1:0] col_of(input logic [POS_W-1:0] pos,
                                             input logic [RC_W-1:0] row);
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] diff;
    base = POS_W'(row) * POS_W'(SQUARE_SIDE);
    diff = pos - base;
    return diff[RC_W-1:0];
  endfunction

  function automatic logic [RC_W-1:0] step_idx(input logic [RC_W-1:0] v, input logic dec);
    if (dec) begin
      return (v == '0) ? RC_W'(SQUARE_SIDE - 1) : v - 1'b1;
    end
    return (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] cell_of(input logic [RC_W-1:0] r,
                                               input logic [RC_W-1:0] c);
    return POS_W'(r) * POS_W'(SQUARE_SIDE) + POS_W'(c);
  endfunction

  pfc_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square (
    .clk     (clk),
    .we      (we),
    .waddr   (wr_pos),
    .wdata   (wr_letter),
    .raddr_a (oa),
    .raddr_b (ob),
    .rdata_a (sq_a),
    .rdata_b (sq_b)
  );

  pfc_ram #(.WIDTH(POS_W), .DEPTH(LETTERS)) u_position (
    .clk     (clk),
    .we      (we),
    .waddr   (wr_letter),
    .wdata   (wr_pos),
    .raddr_a (pa_r),
    .raddr_b (pb_r),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  assign fcode = pfc_pkg::fold_letter((cfg_filler > pfc_pkg::LAST_LETTER) ?
                                      pfc_pkg::LETTER_X : cfg_filler);

  always_comb begin
    ra = row_of(pos_a);
    rb = row_of(pos_b);
    ca = col_of(pos_a, ra);
    cb = col_of(pos_b, rb);
    if (ra == rb) begin
      oa = cell_of(ra, step_idx(ca, cfg_decrypt));
      ob = cell_of(rb, step_idx(cb, cfg_decrypt));
    end else if (ca == cb) begin
      oa = cell_of(step_idx(ra, cfg_decrypt), ca);
      ob = cell_of(step_idx(rb, cfg_decrypt), cb);
    end else begin
      oa = cell_of(ra, cb);
      ob = cell_of(rb, ca);
    end
  end

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    mask_nxt     = mask_r;
    cnt_nxt      = cnt_r;
    ready_nxt    = ready_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    last_nxt     = last_r;
    fill_nxt     = fill_r;
    res_a_nxt    = res_a_r;
    res_b_nxt    = res_b_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_d_nxt    = out_d_r;
    out_last_nxt = out_last_r;
    we           = 1'b0;
    wr_letter    = op.letter;
    wr_pos       = cnt_r[POS_W-1:0];
    op_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          unique case (op.kind)
            pfc_pkg::OP_KEY: begin
              if (ready_r) begin
                mask_nxt   = '0;
                cnt_nxt    = '0;
                ready_nxt  = 1'b0;
                pend_nxt   = '0;
                pend_v_nxt = 1'b0;
              end
              if (op.usable && !mask_nxt[op.letter] && (cnt_nxt < CNT_W'(CELLS))) begin
                we                   = 1'b1;
                wr_letter            = op.letter;
                wr_pos               = cnt_nxt[POS_W-1:0];
                mask_nxt[op.letter]  = 1'b1;
                cnt_nxt              = cnt_nxt + 1'b1;
              end
            end
            pfc_pkg::OP_DONE: begin
              if (!ready_r) begin
                fill_nxt  = '0;
                state_nxt = ST_FILL;
              end
            end
            pfc_pkg::OP_TEXT: begin
              if (ready_r) begin
                if (!pend_v_r) begin
                  pend_nxt   = op.letter;
                  pend_v_nxt = 1'b1;
                end else if (!cfg_decrypt && (op.letter == pend_r)) begin
                  pa_nxt    = pend_r;
                  pb_nxt    = fcode;
                  last_nxt  = 1'b0;
                  pend_nxt  = op.letter;
                  state_nxt = ST_LOOK;
                end else begin
                  pa_nxt     = pend_r;
                  pb_nxt     = op.letter;
                  last_nxt   = 1'b0;
                  pend_nxt   = '0;
                  pend_v_nxt = 1'b0;
                  state_nxt  = ST_LOOK;
                end
              end
            end
            pfc_pkg::OP_END: begin
              if (ready_r && pend_v_r) begin
                pa_nxt     = pend_r;
                pb_nxt     = fcode;
                last_nxt   = 1'b1;
                pend_nxt   = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = ST_LOOK;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        if ((fill_r != pfc_pkg::LETTER_J) && !mask_r[fill_r] && (cnt_r < CNT_W'(CELLS))) begin
          we               = 1'b1;
          wr_letter        = fill_r;
          wr_pos           = cnt_r[POS_W-1:0];
          mask_nxt[fill_r] = 1'b1;
          cnt_nxt          = cnt_r + 1'b1;
        end
        if (fill_r == pfc_pkg::LAST_LETTER) begin
          ready_nxt  = 1'b1;
          pend_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_POS;
      end
      ST_POS: begin
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        res_a_nxt = sq_a;
        res_b_nxt = sq_b;
        state_nxt = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_d_nxt    = res_a_r;
          out_last_nxt = 1'b0;
          state_nxt    = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_d_nxt    = res_b_r;
          out_last_nxt = last_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mask_r   <= '0;
      cnt_r    <= '0;
      ready_r  <= 1'b0;
      pend_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      ready_r  <= ready_nxt;
      pend_r   <= pend_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    last_r     <= last_nxt;
    fill_r     <= fill_nxt;
    res_a_r    <= res_a_nxt;
    res_b_r    <= res_b_nxt;
    out_d_r    <= out_d_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid  = out_v_r;
  assign out_letter = out_d_r;
  assign out_last   = out_last_r;

endmodule

// ----- rtl/playfair_digram_cipher.sv -----
// Top level of the Playfair digram cipher engine.
// Depends on pfc_pkg, pfc_front and pfc_back.
//
// Input stream: in_tuser carries the command (key letter, key done, text
// letter, end of text) and in_tdata the letter code. Each transaction is
// classified by the front end and, unless it is a text letter code above 25,
// placed in a two-entry queue, so in_tready stays high while the queue has
// room. The back end works on one queued operation at a time.
// A key letter is handled in the idle state. Key done walks all 26 letter codes,
// one per cycle, to complete the square. A text pair takes the back end
// through two registered memory lookups (letter position, then square
// cell), a capture state and one emit state per result.
// The first result is loaded into the output register after ST_LOOK, ST_POS
// and ST_SQ; end of text with a letter pending pads it and sets out_tlast on
// the second result.
// Results leave through an output register; when the receiver holds
// out_tready low the back end waits, and the queue in front absorbs up to
// two more input transactions before in_tready drops.
// Reset clears the key, the pending letter, the queue and the output, sets
// encryption and the filler x. The square memories need no clearing pass.
module playfair_digram_cipher #(
  parameter int SQUARE_SIDE = pfc_pkg::SQUARE_SIDE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter
  input  logic [1:0] in_tuser,   // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] out_letter
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [4:0] cfg_wdata
);

  logic                          decrypt_r;
  logic [pfc_pkg::LETTER_W-1:0]  filler_r;
  logic                          op_valid;
  logic                          op_ready;
  pfc_pkg::op_t                  op;
  logic [pfc_pkg::LETTER_W-1:0]  out_letter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
      filler_r  <= pfc_pkg::LETTER_X;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pfc_pkg::REG_DECRYPT: decrypt_r <= cfg_wdata[0];
        pfc_pkg::REG_FILLER:  filler_r  <= cfg_wdata;
      endcase
    end
  end

  pfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_letter (in_tdata[pfc_pkg::LETTER_W-1:0]),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op)
  );

  pfc_back #(.SQUARE_SIDE(SQUARE_SIDE)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op),
    .cfg_decrypt (decrypt_r),
    .cfg_filler  (filler_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_letter  (out_letter),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, out_letter};

endmodule

// ----- rtl/pfc_checker.sv -----
// Port-level checks for the Playfair digram cipher engine.
// Bound to playfair_digram_cipher; no other dependencies.
module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  // A message end is the second letter of a pair; the next pair cannot follow at once.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output continued right after end of message");

  // A burst of results always starts with the first letter of a pair.
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !out_tlast)
    else $error("pair started with end of message mark");

endmodule

bind playfair_digram_cipher pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- dv/tb_playfair_digram_cipher.sv -----
// Self-checking testbench for the Playfair digram cipher engine.
// Builds keys, streams text in both modes and checks every cipher letter.
// Depends on pfc_pkg and playfair_digram_cipher.
`timescale 1ns / 100ps

module tb_playfair_digram_cipher;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 100;
  localparam int LONG_HOLD    = 300;
  localparam int TARGET_ITEMS = 950;
  localparam int CELLS        = SQUARE_SIDE * SQUARE_SIDE;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } cipher_letter_t;

  class cipher_scoreboard;
    logic [LETTER_W-1:0] cell_letter[CELLS];
    logic [LETTER_W-1:0] letter_cell[LETTERS];
    logic [LETTERS-1:0]  used;
    int                  fill;
    bit                  ready;
    logic [LETTER_W-1:0] held;
    bit                  held_valid;
    bit                  decrypt;
    logic [LETTER_W-1:0] filler;
    cipher_letter_t      expected_letters[$];
    int                  errors;
    int                  checked;

    function new();
      clear_key();
      decrypt = 1'b0;
      filler  = LETTER_X;
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_key();
      foreach (cell_letter[i]) cell_letter[i] = '0;
      foreach (letter_cell[i]) letter_cell[i] = '0;
      used       = '0;
      fill       = 0;
      ready      = 1'b0;
      held       = '0;
      held_valid = 1'b0;
    endfunction

    function void write_reg(logic addr, logic [LETTER_W-1:0] data);
      if (addr == REG_DECRYPT) begin
        decrypt = data[0];
      end else begin
        filler = data;
      end
    endfunction

    function void place(logic [LETTER_W-1:0] code);
      if (fill < CELLS) begin
        cell_letter[fill] = code;
        letter_cell[code] = LETTER_W'(fill);
        used[code]        = 1'b1;
        fill++;
      end
    endfunction

    function logic [LETTER_W-1:0] pad_letter();
      logic [LETTER_W-1:0] f;
      f = (filler > LAST_LETTER) ? LETTER_X : filler;
      return (f == LETTER_J) ? LETTER_I : f;
    endfunction

    function int shift_index(int v);
      if (decrypt) begin
        return (v == 0) ? SQUARE_SIDE - 1 : v - 1;
      end
      return (v + 1 >= SQUARE_SIDE) ? 0 : v + 1;
    endfunction

    function void encode_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b, logic last);
      int ra, ca, rb, cb, oa, ob;
      ra = int'(letter_cell[a]) / SQUARE_SIDE;
      ca = int'(letter_cell[a]) % SQUARE_SIDE;
      rb = int'(letter_cell[b]) / SQUARE_SIDE;
      cb = int'(letter_cell[b]) % SQUARE_SIDE;
      if (ra == rb) begin
        oa = ra * SQUARE_SIDE + shift_index(ca);
        ob = rb * SQUARE_SIDE + shift_index(cb);
      end else if (ca == cb) begin
        oa = shift_index(ra) * SQUARE_SIDE + ca;
        ob = shift_index(rb) * SQUARE_SIDE + cb;
      end else begin
        oa = ra * SQUARE_SIDE + cb;
        ob = rb * SQUARE_SIDE + ca;
      end
      expected_letters.push_back('{letter: cell_letter[oa], last: 1'b0});
      expected_letters.push_back('{letter: cell_letter[ob], last: last});
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] code);
      logic [LETTER_W-1:0] t;
      case (cmd)
        CMD_KEY: begin
          if (ready) clear_key();
          if (code <= LAST_LETTER && code != LETTER_J && !used[code]) place(code);
        end
        CMD_DONE: begin
          if (!ready) begin
            for (int i = 0; i < LETTERS; i++) begin
              if (i != LETTER_J && !used[i]) place(LETTER_W'(i));
            end
            ready      = 1'b1;
            held_valid = 1'b0;
            held       = '0;
          end
        end
        CMD_TEXT: begin
          if (ready && code <= LAST_LETTER) begin
            t = (code == LETTER_J) ? LETTER_I : code;
            if (!held_valid) begin
              held       = t;
              held_valid = 1'b1;
            end else if (!decrypt && t == held) begin
              encode_pair(held, pad_letter(), 1'b0);
              held = t;
            end else begin
              encode_pair(held, t, 1'b0);
              held_valid = 1'b0;
              held       = '0;
            end
          end
        end
        CMD_END: begin
          if (ready && held_valid) begin
            encode_pair(held, pad_letter(), 1'b1);
            held_valid = 1'b0;
            held       = '0;
          end
        end
      endcase
    endfunction

    function void check_letter(logic [LETTER_W-1:0] got, logic got_last);
      cipher_letter_t exp;
      if (expected_letters.size() == 0) begin
        errors++;
        $error("out_letter: expected none, actual %0d", got);
        return;
      end
      exp = expected_letters.pop_front();
      checked++;
      if (got !== exp.letter) begin
        errors++;
        $error("out_letter: expected %0d, actual %0d", exp.letter, got);
      end
      if (got_last !== exp.last) begin
        errors++;
        $error("last_of_message: expected %0d, actual %0d", exp.last, got_last);
      end
    endfunction

    function void check_leftover();
      if (expected_letters.size() != 0) begin
        errors++;
        $error("out_letter: expected %0d more results, actual 0", expected_letters.size());
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_we;
  logic       cfg_addr;
  logic [4:0] cfg_wdata;

  cipher_scoreboard sb = new();
  bit burst_mode;
  bit hold_request;
  int useful_items;
  int phase_count;
  int cycle_count;

  playfair_digram_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_command(in_tuser, in_tdata[LETTER_W-1:0]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_letter(out_tdata[LETTER_W-1:0], out_tlast);
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver may stall before each result outside burst mode and takes one long hold when asked.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 4);
      if (hold_request) begin
        stall += LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] code);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, code};
    do @(posedge clk); while (!in_tready);
    useful_items++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_letters.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input bit dec, input logic [LETTER_W-1:0] fill_code);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DECRYPT;
    cfg_wdata <= {4'b0000, dec};
    sb.write_reg(REG_DECRYPT, {4'b0000, dec});
    @(posedge clk);
    cfg_addr  <= REG_FILLER;
    cfg_wdata <= fill_code;
    sb.write_reg(REG_FILLER, fill_code);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter();
    if ($urandom_range(0, 11) == 0) return LETTER_W'($urandom_range(26, 31));
    return LETTER_W'($urandom_range(0, 25));
  endfunction

  task automatic load_key(input int len);
    for (int i = 0; i < len; i++) begin
      send_cmd(CMD_KEY, ($urandom_range(0, 15) == 0) ? LETTER_J : pick_letter());
      if (i == 0 && $urandom_range(0, 7) == 0) send_cmd(CMD_TEXT, pick_letter());
    end
    send_cmd(CMD_DONE, LETTER_W'($urandom_range(0, 31)));
  endtask

  task automatic load_full_key();
    int order[LETTERS];
    int j, t;
    foreach (order[i]) order[i] = i;
    for (int i = LETTERS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_cmd(CMD_KEY, LETTER_W'(order[i]));
    repeat (3) send_cmd(CMD_KEY, LETTER_W'($urandom_range(0, 25)));
    send_cmd(CMD_DONE, LETTER_W'($urandom_range(0, 31)));
  endtask

  task automatic send_text(input int len, input bit close);
    logic [LETTER_W-1:0] prev, code;
    prev = '0;
    for (int i = 0; i < len; i++) begin
      code = (i > 0 && $urandom_range(0, 4) == 0) ? prev : pick_letter();
      send_cmd(CMD_TEXT, code);
      prev = code;
      if ($urandom_range(0, 24) == 0) send_cmd(CMD_DONE, LETTER_W'($urandom_range(0, 31)));
    end
    if (close) send_cmd(CMD_END, LETTER_W'($urandom_range(0, 31)));
  endtask

  initial begin
    bit                  dec_table[10];
    logic [LETTER_W-1:0] fill_table[10];
    bit                  dec;
    logic [LETTER_W-1:0] fill_code;

    dec_table    = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 0};
    fill_table   = '{23, 0, 25, 31, 9, 23, 0, 25, 31, 8};
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= '0;
    cfg_we       <= 1'b0;
    cfg_addr     <= REG_DECRYPT;
    cfg_wdata    <= '0;
    burst_mode   = 1'b0;
    hold_request = 1'b0;
    useful_items = 0;
    phase_count  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Text ahead of any key is dropped; the key has a j, repeats and a bad code.
    send_cmd(CMD_TEXT, 5'd0);
    send_cmd(CMD_END, 5'd0);
    send_cmd(CMD_KEY, 5'd15);
    send_cmd(CMD_KEY, 5'd11);
    send_cmd(CMD_KEY, 5'd0);
    send_cmd(CMD_KEY, 5'd24);
    send_cmd(CMD_KEY, LETTER_J);
    send_cmd(CMD_KEY, 5'd5);
    send_cmd(CMD_KEY, 5'd0);
    send_cmd(CMD_KEY, 5'd31);
    send_cmd(CMD_KEY, LETTER_I);
    send_cmd(CMD_KEY, 5'd17);
    send_cmd(CMD_DONE, 5'd31);
    send_cmd(CMD_DONE, 5'd0);
    // Row pair, column pair, rectangle with a folded j, doubled letter, pad.
    send_cmd(CMD_TEXT, 5'd15);
    send_cmd(CMD_TEXT, 5'd11);
    send_cmd(CMD_TEXT, 5'd15);
    send_cmd(CMD_TEXT, LETTER_I);
    send_cmd(CMD_TEXT, 5'd7);
    send_cmd(CMD_TEXT, LETTER_J);
    send_cmd(CMD_TEXT, 5'd4);
    send_cmd(CMD_TEXT, 5'd4);
    send_cmd(CMD_TEXT, 5'd31);
    send_cmd(CMD_END, 5'd0);
    send_cmd(CMD_END, 5'd31);

    while (useful_items < TARGET_ITEMS) begin
      if (phase_count < 10) begin
        dec       = dec_table[phase_count];
        fill_code = fill_table[phase_count];
      end else begin
        dec       = 1'($urandom_range(0, 1));
        fill_code = LETTER_W'($urandom_range(0, 31));
      end
      wait_idle();
      set_mode(dec, fill_code);
      burst_mode = ($urandom_range(0, 3) == 0);
      if (phase_count == 1) begin
        load_full_key();
      end else if ($urandom_range(0, 2) != 0) begin
        load_key($urandom_range(1, 12));
      end
      if (phase_count == 3) begin
        burst_mode   = 1'b1;
        hold_request = 1'b1;
        send_text(40, 1'b1);
      end else begin
        send_text($urandom_range(4, 24), $urandom_range(0, 4) != 0);
      end
      phase_count++;
    end

    wait_idle();
    sb.check_leftover();
    $display("Run covered %0d input transactions and %0d checked letters in %0d phases,",
             useful_items, sb.checked, phase_count);
    $display("with both cipher modes, all filler settings, key rebuilds and output hold-off.");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
